>>> rtl/icc_pkg.sv
// Shared types and constants for the image CRC-32 checker.
`timescale 1ns / 1ps
`default_nettype none

package icc_pkg;

    localparam int unsigned CrcWidth = 32;

    localparam logic [CrcWidth-1:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CrcWidth-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_EXPECTED_CRC = 1'b0,
        REG_SLOT_SELECT  = 1'b1
    } reg_index_t;

    // Slot codes; any other code raises no error
    localparam logic [1:0] SLOT_A = 2'd0;
    localparam logic [1:0] SLOT_B = 2'd1;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SLOT_A = 2'd1,
        ERR_SLOT_B = 2'd2
    } err_code_t;

    typedef struct packed {
        logic [CrcWidth-1:0] crc;
        logic                match;
        err_code_t           code;
    } icc_result_t;

    // Reflected CRC-32 over one word, byte 0 (bits 7:0) first, LSB first.
    // Unrolls into a plain XOR network.
    function automatic logic [CrcWidth-1:0] crc32_word(
        input logic [CrcWidth-1:0] crc_in,
        input logic [CrcWidth-1:0] data
    );
        logic [CrcWidth-1:0] r;
        r = crc_in ^ data;
        for (int i = 0; i < CrcWidth; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/icc_crc_unit.sv
// Running CRC-32 register with final-word compare and slot error decode.
`timescale 1ns / 1ps
`default_nettype none

module icc_crc_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [icc_pkg::CrcWidth-1:0]  word,
    input  wire logic                          last,
    input  wire logic [icc_pkg::CrcWidth-1:0]  expected_crc,
    input  wire logic [1:0]                    slot_select,
    output icc_pkg::icc_result_t               result
);

    logic [icc_pkg::CrcWidth-1:0] crc_reg;
    logic [icc_pkg::CrcWidth-1:0] crc_next;
    logic [icc_pkg::CrcWidth-1:0] crc_upd;
    logic [icc_pkg::CrcWidth-1:0] crc_final;
    logic                         match;

    assign crc_upd   = icc_pkg::crc32_word(crc_reg, word);
    assign crc_final = crc_upd ^ icc_pkg::CRC_ALL_ONES;
    assign match     = (crc_final == expected_crc);

    always_comb
    begin
        crc_next = crc_reg;
        if (step)
        begin
            // the register restarts after the last word of an image
            crc_next = last ? icc_pkg::CRC_ALL_ONES : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= icc_pkg::CRC_ALL_ONES;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    always_comb
    begin
        result.crc   = crc_final;
        result.match = match;
        result.code  = icc_pkg::ERR_NONE;
        if (!match)
        begin
            case (slot_select)
                icc_pkg::SLOT_A: result.code = icc_pkg::ERR_SLOT_A;
                icc_pkg::SLOT_B: result.code = icc_pkg::ERR_SLOT_B;
                default:         result.code = icc_pkg::ERR_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/image_crc32_checker_top.sv
// Top level of the image CRC-32 checker: input register, CRC unit, result register.
// A final word's result is registered in the result register once the word leaves the CRC stage.
// Throughput: one image word per cycle; the CRC unit folds a whole word per cycle.
// A pending result in the output register stalls intake only when a second final
// word reaches the CRC stage before the first result is taken.
// Reset: CRC register to all ones, expected_crc and slot_select to zero, both
// pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module image_crc32_checker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] image_word,
    input  wire logic        final_word,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      computed_crc,
    output logic             crc_match,
    output logic [1:0]       error_code
);

    logic [31:0] expected_crc_reg;
    logic [1:0]  slot_select_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_word_reg;
    logic        s1_last_reg;
    logic        s1_move;
    logic        in_fire;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    icc_pkg::icc_result_t  out_reg;
    icc_pkg::icc_result_t  crc_result;
    logic                  out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_crc_reg <= '0;
            slot_select_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (icc_pkg::reg_index_t'(cfg_index))
                icc_pkg::REG_EXPECTED_CRC: expected_crc_reg <= cfg_data;
                icc_pkg::REG_SLOT_SELECT:  slot_select_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // a final word needs a free result slot; other words always pass
    assign s1_move  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;
    assign out_load = s1_move && s1_last_reg;

    assign s1_valid_next  = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign out_valid_next = out_load ? 1'b1 : ((out_valid_reg && out_ready) ? 1'b0
                                                                          : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_word_reg <= image_word;
            s1_last_reg <= final_word;
        end
        if (out_load)
        begin
            out_reg <= crc_result;
        end
    end

    icc_crc_unit u_crc (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_move),
        .word         (s1_word_reg),
        .last         (s1_last_reg),
        .expected_crc (expected_crc_reg),
        .slot_select  (slot_select_reg),
        .result       (crc_result)
    );

    assign out_valid    = out_valid_reg;
    assign computed_crc = out_reg.crc;
    assign crc_match    = out_reg.match;
    assign error_code   = out_reg.code;

    // an empty result register never blocks intake
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("intake stalled with empty result register");

    // a final word held in the CRC stage only waits on a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> (s1_last_reg && out_valid_reg && !out_ready))
        else $error("CRC stage stalled without cause");

    // a reported error always comes with a mismatch
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.code != icc_pkg::ERR_NONE)) |-> !out_reg.match)
        else $error("error code raised on a matching CRC");

    // a result is loaded exactly when a final word leaves the CRC stage
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("final word left CRC stage without a result");

endmodule

`default_nettype wire
